[hw/rtl/bcc_pkg.sv]
// Shared types, constants and helper functions of the Bech32 checksum codec.
`default_nettype none

package bcc_pkg;

  localparam int PREFIX_DEPTH = 128;
  localparam int MAX_LENGTH   = 90;
  localparam int PCW          = $clog2(PREFIX_DEPTH + 1);
  localparam int AW           = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;

  localparam logic [6:0]  MAX_LEN   = 7'(MAX_LENGTH);
  localparam logic [6:0]  LEN_SAT   = 7'd127;
  localparam logic [6:0]  MIN_DATA  = 7'd6;
  localparam logic [7:0]  CHAR_MIN  = 8'd33;
  localparam logic [7:0]  CHAR_MAX  = 8'd126;
  localparam logic [7:0]  VALUE_LIM = 8'd32;

  localparam logic [29:0] CHK_INIT           = 30'd1;
  localparam logic [29:0] BECH32_TARGET_RST  = 30'd1;
  localparam logic [29:0] BECH32M_TARGET_RST = 30'h2bc830a3;

  localparam logic [29:0] GEN0 = 30'h3b6a57b2;
  localparam logic [29:0] GEN1 = 30'h26508e6d;
  localparam logic [29:0] GEN2 = 30'h1ea119fa;
  localparam logic [29:0] GEN3 = 30'h3d4233dd;
  localparam logic [29:0] GEN4 = 30'h2a1462b3;

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef enum logic [2:0] {
    OP_PREFIX        = 3'd0,
    OP_DATA_VALUE    = 3'd1,
    OP_DATA_CHAR     = 3'd2,
    OP_FINISH_GEN    = 3'd3,
    OP_FINISH_VERIFY = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_VALUE_RANGE     = 3'd1,
    ST_BAD_CHAR        = 3'd2,
    ST_BAD_PREFIX_CHAR = 3'd3,
    ST_PREFIX_LENGTH   = 3'd4,
    ST_TOO_SHORT       = 3'd5,
    ST_TOO_LONG        = 3'd6
  } status_t;

  typedef enum logic {
    CFG_BECH32_TARGET  = 1'b0,
    CFG_BECH32M_TARGET = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [6:0] len;
    logic       over;
  } len_step_t;

  typedef struct packed {
    logic       found;
    logic [4:0] val;
  } char_lookup_t;

  function automatic logic [29:0] fold(input logic [29:0] rc, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] c;
    top = rc[29:25];
    c   = {rc[24:0], v};
    if (top[0]) c = c ^ GEN0;
    if (top[1]) c = c ^ GEN1;
    if (top[2]) c = c ^ GEN2;
    if (top[3]) c = c ^ GEN3;
    if (top[4]) c = c ^ GEN4;
    return c;
  endfunction

  function automatic status_t note(input status_t sticky, input status_t code);
    return (sticky == ST_OK) ? code : sticky;
  endfunction

  function automatic len_step_t bump_length(input logic [6:0] len);
    len_step_t r;
    logic      sat;
    sat    = (len == LEN_SAT);
    r.len  = sat ? len : len + 7'd1;
    r.over = sat || (r.len > MAX_LEN);
    return r;
  endfunction

  function automatic logic [7:0] charset_char(input logic [4:0] v);
    return CHARSET[8 * (31 - int'(v)) +: 8];
  endfunction

  function automatic char_lookup_t charset_value(input logic [7:0] ch);
    char_lookup_t r;
    r.found = 1'b0;
    r.val   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (CHARSET[8 * (31 - i) +: 8] == ch) begin
        r.found = 1'b1;
        r.val   = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bech32_checksum_codec_core.sv]
// Bech32 / Bech32m checksum codec core: prefix store, polymod and result register.
//
// Usage: one address is streamed per session. Requests arrive on the in_* channel
// (opcode, symbol, variant); results leave on the out_* channel, one per request,
// six for finish-generate, with last on the final one. Unknown opcodes give none.
// The cfg_* channel writes the two xor targets; it is always ready.
// The first data or finish request of an address first folds a zero and then walks
// the prefix memory. Finish-generate further folds six zeros and then emits the six
// checksum characters in turn.
// Throughput: one request in flight; a new request is taken once the previous one
// has written its last result into the output register, even while that result
// still waits for out_ready.
// Reset (rst, synchronous) clears the checksum, counters, phase, sticky error and
// the output valid flag, and restores both targets. The prefix memory is not
// cleared; only entries written in the current address are read.
// A stalled receiver holds the output register; the core then waits before
// writing the next result.
`default_nettype none

module bech32_checksum_codec_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] symbol,
  input  wire logic       variant,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      symbol_out,
  output logic [2:0]      status,
  output logic            matches_bech32,
  output logic            matches_bech32m,
  output logic            last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [29:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ENTER = 6'b000010,
    S_SWEEP = 6'b000100,
    S_EXEC  = 6'b001000,
    S_GFOLD = 6'b010000,
    S_GEMIT = 6'b100000
  } state_t;

  state_t                      state, state_next;
  bcc_pkg::opcode_t            op_q, op_q_next;
  logic [7:0]                  sym_q, sym_q_next;
  logic                        var_q, var_q_next;
  logic [29:0]                 rc, rc_next;
  logic [6:0]                  tl, tl_next;
  logic [6:0]                  dc, dc_next;
  logic [bcc_pkg::PCW-1:0]     pc, pc_next;
  logic                        in_data_phase, in_data_phase_next;
  bcc_pkg::status_t            sticky, sticky_next;
  bcc_pkg::status_t            ecode, ecode_next;
  logic [bcc_pkg::PCW-1:0]     sweep_cnt, sweep_cnt_next;
  logic                        rd_vld, rd_vld_next;
  logic [2:0]                  cnt, cnt_next;
  logic [29:0]                 p_sh, p_sh_next;
  bcc_pkg::status_t            gst, gst_next;
  logic [29:0]                 t0, t1;

  logic                        out_free, out_load;
  logic [7:0]                  o_sym;
  bcc_pkg::status_t            o_st;
  logic                        o_m0, o_m1, o_last;

  logic [4:0]                  prefix_mem [bcc_pkg::PREFIX_DEPTH];
  logic [4:0]                  mem_q;
  logic                        mem_we, mem_re;
  logic [bcc_pkg::AW-1:0]      rd_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    bcc_pkg::len_step_t    lb;
    bcc_pkg::status_t      code;
    bcc_pkg::char_lookup_t cv;
    logic [29:0]           rc_f;
    state_t                after_enter;

    state_next         = state;
    op_q_next          = op_q;
    sym_q_next         = sym_q;
    var_q_next         = var_q;
    rc_next            = rc;
    tl_next            = tl;
    dc_next            = dc;
    pc_next            = pc;
    in_data_phase_next = in_data_phase;
    sticky_next        = sticky;
    ecode_next         = ecode;
    sweep_cnt_next     = sweep_cnt;
    rd_vld_next        = rd_vld;
    cnt_next           = cnt;
    p_sh_next          = p_sh;
    gst_next           = gst;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    rd_addr            = sweep_cnt[bcc_pkg::AW-1:0];
    out_load           = 1'b0;
    o_sym              = 8'd0;
    o_st               = bcc_pkg::ST_OK;
    o_m0               = 1'b0;
    o_m1               = 1'b0;
    o_last             = 1'b0;
    lb                 = bcc_pkg::bump_length(tl);
    code               = bcc_pkg::ST_OK;
    cv                 = bcc_pkg::charset_value(sym_q);
    rc_f               = bcc_pkg::fold(rc, 5'd0);
    after_enter        = (op_q == bcc_pkg::OP_FINISH_GEN) ? S_GFOLD : S_EXEC;

    case (state)
      S_IDLE: begin
        op_q_next  = bcc_pkg::opcode_t'(opcode);
        sym_q_next = symbol;
        var_q_next = variant;
        ecode_next = bcc_pkg::ST_OK;
        cnt_next   = 3'd0;
        if (in_valid) begin
          case (opcode)
            bcc_pkg::OP_PREFIX: state_next = S_EXEC;
            bcc_pkg::OP_DATA_VALUE, bcc_pkg::OP_DATA_CHAR, bcc_pkg::OP_FINISH_VERIFY: begin
              state_next = in_data_phase ? S_EXEC : S_ENTER;
            end
            bcc_pkg::OP_FINISH_GEN: state_next = in_data_phase ? S_GFOLD : S_ENTER;
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_ENTER: begin
        tl_next            = lb.len;
        code               = (pc == '0) ? bcc_pkg::ST_PREFIX_LENGTH : bcc_pkg::ST_OK;
        sticky_next        = bcc_pkg::note(bcc_pkg::note(sticky, code),
                               lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
        ecode_next         = (code != bcc_pkg::ST_OK) ? code :
                             (lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
        rc_next            = rc_f;
        in_data_phase_next = 1'b1;
        sweep_cnt_next     = '0;
        rd_vld_next        = 1'b0;
        state_next         = S_SWEEP;
      end

      S_SWEEP: begin
        if (rd_vld) rc_next = bcc_pkg::fold(rc, mem_q);
        if (sweep_cnt != pc) begin
          mem_re         = 1'b1;
          sweep_cnt_next = sweep_cnt + bcc_pkg::PCW'(1);
          rd_vld_next    = 1'b1;
        end else begin
          rd_vld_next = 1'b0;
          if (!rd_vld) state_next = after_enter;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_last     = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            bcc_pkg::OP_PREFIX: begin
              if (in_data_phase) begin
                sticky_next = bcc_pkg::note(sticky, bcc_pkg::ST_BAD_PREFIX_CHAR);
                o_st        = bcc_pkg::ST_BAD_PREFIX_CHAR;
              end else if (pc >= bcc_pkg::PCW'(bcc_pkg::PREFIX_DEPTH)) begin
                sticky_next = bcc_pkg::note(sticky, bcc_pkg::ST_PREFIX_LENGTH);
                o_st        = bcc_pkg::ST_PREFIX_LENGTH;
              end else begin
                code        = (sym_q < bcc_pkg::CHAR_MIN || sym_q > bcc_pkg::CHAR_MAX) ?
                              bcc_pkg::ST_BAD_PREFIX_CHAR : bcc_pkg::ST_OK;
                sticky_next = bcc_pkg::note(bcc_pkg::note(sticky, code),
                                lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
                rc_next     = bcc_pkg::fold(rc, {2'b00, sym_q[7:5]});
                mem_we      = 1'b1;
                pc_next     = pc + bcc_pkg::PCW'(1);
                tl_next     = lb.len;
                o_st        = (code != bcc_pkg::ST_OK) ? code :
                              (lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
              end
            end
            bcc_pkg::OP_DATA_VALUE, bcc_pkg::OP_DATA_CHAR: begin
              if (op_q == bcc_pkg::OP_DATA_VALUE && sym_q >= bcc_pkg::VALUE_LIM) begin
                sticky_next = bcc_pkg::note(sticky, bcc_pkg::ST_VALUE_RANGE);
                o_st        = bcc_pkg::ST_VALUE_RANGE;
              end else if (op_q == bcc_pkg::OP_DATA_CHAR && !cv.found) begin
                sticky_next = bcc_pkg::note(sticky, bcc_pkg::ST_BAD_CHAR);
                o_st        = bcc_pkg::ST_BAD_CHAR;
              end else begin
                if (op_q == bcc_pkg::OP_DATA_VALUE) begin
                  rc_next = bcc_pkg::fold(rc, sym_q[4:0]);
                  o_sym   = bcc_pkg::charset_char(sym_q[4:0]);
                end else begin
                  rc_next = bcc_pkg::fold(rc, cv.val);
                  o_sym   = {3'b000, cv.val};
                end
                dc_next     = (dc != bcc_pkg::LEN_SAT) ? dc + 7'd1 : dc;
                tl_next     = lb.len;
                sticky_next = bcc_pkg::note(sticky,
                                lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
                o_st        = (ecode != bcc_pkg::ST_OK) ? ecode :
                              (lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
              end
            end
            bcc_pkg::OP_FINISH_VERIFY: begin
              o_st = bcc_pkg::note(sticky,
                       (dc < bcc_pkg::MIN_DATA) ? bcc_pkg::ST_TOO_SHORT : bcc_pkg::ST_OK);
              o_m0 = (rc == t0);
              o_m1 = (rc == t1);
              rc_next            = bcc_pkg::CHK_INIT;
              pc_next            = '0;
              tl_next            = 7'd0;
              dc_next            = 7'd0;
              in_data_phase_next = 1'b0;
              sticky_next        = bcc_pkg::ST_OK;
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end

      S_GFOLD: begin
        rc_next     = rc_f;
        tl_next     = lb.len;
        sticky_next = bcc_pkg::note(sticky, lb.over ? bcc_pkg::ST_TOO_LONG : bcc_pkg::ST_OK);
        cnt_next    = cnt + 3'd1;
        if (cnt == 3'd5) begin
          p_sh_next          = rc_f ^ (var_q ? t1 : t0);
          gst_next           = sticky_next;
          cnt_next           = 3'd0;
          rc_next            = bcc_pkg::CHK_INIT;
          pc_next            = '0;
          tl_next            = 7'd0;
          dc_next            = 7'd0;
          in_data_phase_next = 1'b0;
          sticky_next        = bcc_pkg::ST_OK;
          state_next         = S_GEMIT;
        end
      end

      S_GEMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_sym     = bcc_pkg::charset_char(p_sh[29:25]);
          o_st      = gst;
          o_last    = (cnt == 3'd5);
          p_sh_next = {p_sh[24:0], 5'd0};
          cnt_next  = cnt + 3'd1;
          if (cnt == 3'd5) state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rc            <= bcc_pkg::CHK_INIT;
      tl            <= 7'd0;
      dc            <= 7'd0;
      pc            <= '0;
      in_data_phase <= 1'b0;
      sticky        <= bcc_pkg::ST_OK;
      rd_vld        <= 1'b0;
      cnt           <= 3'd0;
      out_valid     <= 1'b0;
      t0            <= bcc_pkg::BECH32_TARGET_RST;
      t1            <= bcc_pkg::BECH32M_TARGET_RST;
    end else begin
      state         <= state_next;
      rc            <= rc_next;
      tl            <= tl_next;
      dc            <= dc_next;
      pc            <= pc_next;
      in_data_phase <= in_data_phase_next;
      sticky        <= sticky_next;
      rd_vld        <= rd_vld_next;
      cnt           <= cnt_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == bcc_pkg::CFG_BECH32_TARGET) t0 <= cfg_data;
        else t1 <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    sym_q     <= sym_q_next;
    var_q     <= var_q_next;
    ecode     <= ecode_next;
    sweep_cnt <= sweep_cnt_next;
    p_sh      <= p_sh_next;
    gst       <= gst_next;
    if (out_load) begin
      symbol_out      <= o_sym;
      status          <= o_st;
      matches_bech32  <= o_m0;
      matches_bech32m <= o_m1;
      last            <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) prefix_mem[pc[bcc_pkg::AW-1:0]] <= sym_q[4:0];
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_q <= prefix_mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (sweep_cnt <= pc))
    else $error("prefix sweep ran past stored count");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= bcc_pkg::PCW'(bcc_pkg::PREFIX_DEPTH))
    else $error("prefix count beyond memory depth");

  a_sweep_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> in_data_phase)
    else $error("prefix sweep outside data phase");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("prefix memory read and write in one cycle");

  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEMIT) |-> (cnt <= 3'd5))
    else $error("checksum emit count out of range");
`endif

endmodule

`default_nettype wire

[tb/tb_bech32_checksum_codec_core.sv]
// Testbench for the Bech32 checksum codec core: directed table, then random addresses.
`timescale 1ns / 1ps

module tb_bech32_checksum_codec_core;
  import bcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 250;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_OFF       = 400;
  localparam int N_DIRECTED     = 24;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam string ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [7:0] sym;
    status_t    st;
    logic       m0;
    logic       m1;
    logic       fin;
  } codec_result_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] sym;
    logic       vsel;
    logic       typed;
    logic [7:0] t_sym;
    status_t    t_st;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_DATA_VALUE,    8'd0,   1'b0, 1'b1, "q",   ST_PREFIX_LENGTH},
    '{OP_FINISH_VERIFY, 8'd0,   1'b0, 1'b1, 8'd0,  ST_PREFIX_LENGTH},
    '{OP_PREFIX,        "b",    1'b0, 1'b1, 8'd0,  ST_OK},
    '{OP_PREFIX,        "c",    1'b1, 1'b1, 8'd0,  ST_OK},
    '{OP_PREFIX,        8'd32,  1'b0, 1'b1, 8'd0,  ST_BAD_PREFIX_CHAR},
    '{OP_PREFIX,        8'd127, 1'b0, 1'b1, 8'd0,  ST_BAD_PREFIX_CHAR},
    '{OP_PREFIX,        8'd33,  1'b0, 1'b1, 8'd0,  ST_OK},
    '{OP_PREFIX,        8'd126, 1'b0, 1'b1, 8'd0,  ST_OK},
    '{OP_PREFIX,        8'd255, 1'b1, 1'b1, 8'd0,  ST_BAD_PREFIX_CHAR},
    '{OP_DATA_VALUE,    8'd31,  1'b0, 1'b1, "l",   ST_OK},
    '{OP_DATA_VALUE,    8'd32,  1'b0, 1'b1, 8'd0,  ST_VALUE_RANGE},
    '{OP_DATA_VALUE,    8'd255, 1'b1, 1'b1, 8'd0,  ST_VALUE_RANGE},
    '{OP_DATA_CHAR,     "q",    1'b0, 1'b1, 8'd0,  ST_OK},
    '{OP_DATA_CHAR,     "l",    1'b0, 1'b1, 8'd31, ST_OK},
    '{OP_DATA_CHAR,     "A",    1'b0, 1'b1, 8'd0,  ST_BAD_CHAR},
    '{OP_DATA_CHAR,     8'd0,   1'b0, 1'b1, 8'd0,  ST_BAD_CHAR},
    '{OP_PREFIX,        "x",    1'b0, 1'b1, 8'd0,  ST_BAD_PREFIX_CHAR},
    '{OP_UNUSED_LO,     8'd0,   1'b0, 1'b0, 8'd0,  ST_OK},
    '{OP_FINISH_GEN,    8'd0,   1'b1, 1'b0, 8'd0,  ST_OK},
    '{OP_PREFIX,        "a",    1'b0, 1'b1, 8'd0,  ST_OK},
    '{OP_FINISH_VERIFY, 8'd0,   1'b0, 1'b1, 8'd0,  ST_TOO_SHORT},
    '{OP_UNUSED_HI,     8'd255, 1'b1, 1'b0, 8'd0,  ST_OK},
    '{OP_FINISH_GEN,    8'd0,   1'b0, 1'b0, 8'd0,  ST_OK},
    '{OP_FINISH_VERIFY, 8'd0,   1'b0, 1'b1, 8'd0,  ST_PREFIX_LENGTH}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [7:0]  symbol;
  logic        variant;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  symbol_out;
  logic [2:0]  status;
  logic        matches_bech32;
  logic        matches_bech32m;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [29:0] cfg_data;

  bech32_checksum_codec_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .symbol          (symbol),
    .variant         (variant),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .symbol_out      (symbol_out),
    .status          (status),
    .matches_bech32  (matches_bech32),
    .matches_bech32m (matches_bech32m),
    .last            (last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // checksum state tracked alongside the core
  logic [29:0]   chk;
  logic [4:0]    hrp_low [PREFIX_DEPTH];
  int            hrp_cnt;
  int            addr_len;
  int            data_cnt;
  bit            in_data;
  status_t       sticky;
  logic [29:0]   tgt_b32;
  logic [29:0]   tgt_b32m;
  logic [7:0]    gen_chars [6];
  codec_result_t pending_results [$];

  int err_count;
  int items_sent;
  int stall_cycles;
  bit calm;
  bit hold_off_req;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [7:0] alpha_char(input logic [4:0] v);
    return 8'(ALPHABET[int'(v)]);
  endfunction

  function automatic void mix(input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] c;
    top = chk[29:25];
    c   = {chk[24:0], v};
    if (top[0]) c ^= GEN0;
    if (top[1]) c ^= GEN1;
    if (top[2]) c ^= GEN2;
    if (top[3]) c ^= GEN3;
    if (top[4]) c ^= GEN4;
    chk = c;
  endfunction

  function automatic void flag(input status_t code);
    if (sticky == ST_OK && code != ST_OK) sticky = code;
  endfunction

  function automatic status_t count_char();
    bit sat;
    sat = (addr_len >= int'(LEN_SAT));
    if (!sat) addr_len++;
    if (sat || addr_len > MAX_LENGTH) begin
      flag(ST_TOO_LONG);
      return ST_TOO_LONG;
    end
    return ST_OK;
  endfunction

  function automatic status_t open_data();
    status_t code;
    status_t r;
    if (in_data) return ST_OK;
    code = ST_OK;
    if (hrp_cnt == 0) begin
      flag(ST_PREFIX_LENGTH);
      code = ST_PREFIX_LENGTH;
    end
    r = count_char();
    if (code == ST_OK) code = r;
    mix(5'd0);
    for (int i = 0; i < hrp_cnt; i++) mix(hrp_low[i]);
    in_data = 1'b1;
    return code;
  endfunction

  function automatic void clear_addr();
    chk      = CHK_INIT;
    hrp_cnt  = 0;
    addr_len = 0;
    data_cnt = 0;
    in_data  = 1'b0;
    sticky   = ST_OK;
  endfunction

  function automatic void push_result(input logic [7:0] sym, input status_t st,
                                      input logic m0, input logic m1, input logic fin);
    codec_result_t r;
    r.sym = sym;
    r.st  = st;
    r.m0  = m0;
    r.m1  = m1;
    r.fin = fin;
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict(input logic [2:0] op, input logic [7:0] sym,
                                  input logic vsel);
    status_t     code;
    status_t     r;
    logic [4:0]  val;
    logic [7:0]  outsym;
    logic [29:0] p;
    bit          found;
    case (op)
      OP_PREFIX: begin
        if (in_data) begin
          flag(ST_BAD_PREFIX_CHAR);
          push_result(8'd0, ST_BAD_PREFIX_CHAR, 1'b0, 1'b0, 1'b1);
        end else if (hrp_cnt >= PREFIX_DEPTH) begin
          flag(ST_PREFIX_LENGTH);
          push_result(8'd0, ST_PREFIX_LENGTH, 1'b0, 1'b0, 1'b1);
        end else begin
          code = (sym < CHAR_MIN || sym > CHAR_MAX) ? ST_BAD_PREFIX_CHAR : ST_OK;
          flag(code);
          mix({2'b00, sym[7:5]});
          hrp_low[hrp_cnt] = sym[4:0];
          hrp_cnt++;
          r = count_char();
          if (code == ST_OK) code = r;
          push_result(8'd0, code, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_DATA_VALUE, OP_DATA_CHAR: begin
        code  = open_data();
        found = 1'b0;
        val   = 5'd0;
        if (op == OP_DATA_VALUE) begin
          found  = (sym < VALUE_LIM);
          val    = sym[4:0];
          outsym = alpha_char(val);
          if (!found) flag(ST_VALUE_RANGE);
        end else begin
          for (int i = 0; i < 32; i++) begin
            if (!found && 8'(ALPHABET[i]) == sym) begin
              found = 1'b1;
              val   = 5'(i);
            end
          end
          outsym = {3'b000, val};
          if (!found) flag(ST_BAD_CHAR);
        end
        if (!found) begin
          push_result(8'd0, (op == OP_DATA_VALUE) ? ST_VALUE_RANGE : ST_BAD_CHAR,
                      1'b0, 1'b0, 1'b1);
        end else begin
          mix(val);
          if (data_cnt < int'(LEN_SAT)) data_cnt++;
          r = count_char();
          if (code == ST_OK) code = r;
          push_result(outsym, code, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_FINISH_GEN: begin
        void'(open_data());
        for (int i = 0; i < 6; i++) begin
          mix(5'd0);
          void'(count_char());
        end
        p = chk ^ (vsel ? tgt_b32m : tgt_b32);
        for (int i = 0; i < 6; i++) begin
          gen_chars[i] = alpha_char(5'(p >> (5 * (5 - i))));
          push_result(gen_chars[i], sticky, 1'b0, 1'b0, i == 5);
        end
        clear_addr();
      end
      OP_FINISH_VERIFY: begin
        void'(open_data());
        if (data_cnt < int'(MIN_DATA)) flag(ST_TOO_SHORT);
        push_result(8'd0, sticky, chk == tgt_b32, chk == tgt_b32m, 1'b1);
        clear_addr();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [7:0] sym, input logic vsel,
                           input logic typed, input logic [7:0] t_sym, input status_t t_st);
    int            gap;
    codec_result_t row;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    symbol   <= sym;
    variant  <= vsel;
    do @(posedge clk); while (!in_ready);
    predict(op, sym, vsel);
    if (typed) begin
      row     = pending_results[pending_results.size() - 1];
      row.sym = t_sym;
      row.st  = t_st;
      pending_results[pending_results.size() - 1] = row;
    end
    if (op <= OP_FINISH_VERIFY) items_sent++;
  endtask

  task automatic send(input logic [2:0] op, input logic [7:0] sym, input logic vsel);
    send_item(op, sym, vsel, 1'b0, 8'd0, ST_OK);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) send(3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic feed_address(input logic [7:0] hrp [$], input logic [4:0] dat [$],
                              input bit noisy);
    foreach (hrp[k]) begin
      if (noisy) maybe_noise();
      send(OP_PREFIX, hrp[k], 1'($urandom));
    end
    foreach (dat[k]) begin
      if (noisy) maybe_noise();
      if ($urandom_range(0, 1) == 0) send(OP_DATA_VALUE, {3'b000, dat[k]}, 1'($urandom));
      else send(OP_DATA_CHAR, alpha_char(dat[k]), 1'($urandom));
    end
  endtask

  // negative lengths pick at random; a random address may replay a generate as a verify
  task automatic run_address(input int want_plen, input int want_dlen);
    logic [7:0] hrp [$];
    logic [4:0] dat [$];
    int         plen;
    int         dlen;
    int         pick;
    logic       vsel;
    calm = ($urandom_range(0, 4) == 0);
    if (want_plen >= 0) plen = want_plen;
    else plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    if (want_dlen >= 0) dlen = want_dlen;
    else dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 92) : $urandom_range(0, 16);
    for (int k = 0; k < plen; k++) hrp = {hrp, 8'($urandom_range(CHAR_MIN, CHAR_MAX))};
    for (int k = 0; k < dlen; k++) dat = {dat, 5'($urandom)};
    vsel = 1'($urandom);
    pick = (want_plen >= 0) ? 2 : $urandom_range(0, 2);
    feed_address(hrp, dat, 1'b1);
    if (pick == 2) begin
      send(OP_FINISH_VERIFY, 8'($urandom), vsel);
    end else begin
      send(OP_FINISH_GEN, 8'($urandom), vsel);
      if (pick == 0) begin
        feed_address(hrp, dat, 1'b0);
        for (int k = 0; k < 6; k++) send(OP_DATA_CHAR, gen_chars[k], 1'b0);
        send(OP_FINISH_VERIFY, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_targets(input logic [29:0] b32, input logic [29:0] b32m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BECH32_TARGET;
    cfg_data  <= b32;
    do @(posedge clk); while (!cfg_ready);
    tgt_b32 = b32;
    @(negedge clk);
    cfg_index <= CFG_BECH32M_TARGET;
    cfg_data  <= b32m;
    do @(posedge clk); while (!cfg_ready);
    tgt_b32m = b32m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rx_gap;
    rx_gap    = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_gap       = HOLD_OFF;
      end
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $error("result with no request pending: symbol_out %0h status %0d",
               symbol_out, status);
      end else begin
        want = pending_results.pop_front();
        if (symbol_out !== want.sym) begin
          err_count++;
          $error("symbol_out: expected %0h, got %0h", want.sym, symbol_out);
        end
        if (status !== want.st) begin
          err_count++;
          $error("status: expected %0d, got %0d", want.st, status);
        end
        if (matches_bech32 !== want.m0) begin
          err_count++;
          $error("matches_bech32: expected %0b, got %0b", want.m0, matches_bech32);
        end
        if (matches_bech32m !== want.m1) begin
          err_count++;
          $error("matches_bech32m: expected %0b, got %0b", want.m1, matches_bech32m);
        end
        if (last !== want.fin) begin
          err_count++;
          $error("last: expected %0b, got %0b", want.fin, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int random_base;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_PREFIX;
    symbol       = 8'd0;
    variant      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_BECH32_TARGET;
    cfg_data     = 30'd0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    err_count    = 0;
    items_sent   = 0;
    stall_cycles = 0;
    tgt_b32      = BECH32_TARGET_RST;
    tgt_b32m     = BECH32M_TARGET_RST;
    clear_addr();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].vsel,
                DIRECTED[i].typed, DIRECTED[i].t_sym, DIRECTED[i].t_st);
    end

    random_base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1:       set_targets(30'd0, 30'd0);
          2:       set_targets('1, '1);
          default: set_targets(30'($urandom), 30'($urandom));
        endcase
      end
      // overlong prefix that also runs past the length limit, then a short address
      // sent while the receiver holds off
      if (ph == 1) run_address(PREFIX_DEPTH + 2, 3);
      if (ph == 2) begin
        hold_off_req = 1'b1;
        run_address(4, 12);
      end
      while (items_sent < random_base + (ph + 1) * RANDOM_ITEMS / 4) run_address(-1, -1);
    end
    drain();

    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
